### rtl/hid_report_to_scancode_set1_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the report-to-scancode translator
// Shared property forms, clocked on i_clk and gated by i_rst_n where needed.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_TO_SCANCODE_SET1_TOP_DEFINES_SVH
`define HID_REPORT_TO_SCANCODE_SET1_TOP_DEFINES_SVH

// condition must never hold outside reset
`define HIDSC1_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle, outside reset
`define HIDSC1_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, reset included
`define HIDSC1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hidsc1_pkg.sv
// ----------------------------------------------------------------------------
// hidsc1_pkg
// Constants, usage-to-set-1 table and queue entry type of the translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hidsc1_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int N_CODES   = 'h47;

    // scancode positions within one run
    localparam int POS_MOD_MAKE  = 0;
    localparam int POS_MOD_BREAK = 1;
    localparam int POS_CTRL_TAIL = 2;
    localparam int POS_KEY_MAKE  = 3;
    localparam int POS_KEY_BREAK = POS_KEY_MAKE + KEY_SLOTS;
    localparam int NPOS          = POS_KEY_BREAK + KEY_SLOTS;

    localparam logic [7:0] MOD_CTRL    = 8'd1;
    localparam logic [7:0] MOD_LSHIFT  = 8'd2;
    localparam logic [7:0] MOD_RSHIFT  = 8'd32;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] SHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] CTRL_MAKE   = 8'd29;
    localparam logic [7:0] SHIFT_BREAK = SHIFT_MAKE | BREAK_BIT;
    localparam logic [7:0] CTRL_BREAK  = CTRL_MAKE | BREAK_BIT;

    localparam logic [7:0] USAGE_TO_SET1 [N_CODES] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
        8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00
    };

    typedef struct packed {
        logic [NPOS-1:0]       pend;
        logic [NPOS-1:0][7:0]  seq;
    } t_job;

    function automatic logic in_range(input logic [7:0] code);
        return code < 8'(N_CODES);
    endfunction

    function automatic logic [7:0] usage_map(input logic [7:0] code);
        logic [7:0] r;
        r = 8'h00;
        if (in_range(code)) begin
            r = USAGE_TO_SET1[code[6:0]];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/hidsc1_fifo.sv
// ----------------------------------------------------------------------------
// hidsc1_fifo
// Short queue of scancode runs between the classifier and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hidsc1_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hidsc1_pkg::t_job  i_job,
    output logic                   o_full,
    input  wire logic              i_pop,
    output hidsc1_pkg::t_job       o_job,
    output logic                   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hidsc1_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/hidsc1_front.sv
// ----------------------------------------------------------------------------
// hidsc1_front
// Compare each report with the previous one and build its scancode run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hidsc1_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_modifier_bits,
    input  wire logic [7:0]        i_keys [hidsc1_pkg::KEY_SLOTS],
    input  wire logic              i_full,
    output logic                   o_push,
    output hidsc1_pkg::t_job       o_job
);

    localparam int S = hidsc1_pkg::KEY_SLOTS;

    logic [7:0]   r_prior_mod;
    logic [7:0]   r_prior_keys [S];
    logic [S-1:0] held_new;
    logic [S-1:0] held_old;
    logic         new_shift;
    logic         prior_shift;
    logic         accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_job.pend != '0);

    always_comb begin
        held_new    = '0;
        held_old    = '0;
        o_job       = '0;
        new_shift   = i_modifier_bits inside {hidsc1_pkg::MOD_LSHIFT, hidsc1_pkg::MOD_RSHIFT};
        prior_shift = r_prior_mod inside {hidsc1_pkg::MOD_LSHIFT, hidsc1_pkg::MOD_RSHIFT};

        for (int i = 0; i < S; i++) begin
            for (int j = 0; j < S; j++) begin
                if (r_prior_keys[j] == i_keys[i]) begin
                    held_new[i] = 1'b1;
                end
                if (i_keys[j] == r_prior_keys[i]) begin
                    held_old[i] = 1'b1;
                end
            end
        end

        if (new_shift && (r_prior_mod != i_modifier_bits)) begin
            o_job.pend[hidsc1_pkg::POS_MOD_MAKE] = 1'b1;
            o_job.seq[hidsc1_pkg::POS_MOD_MAKE]  = hidsc1_pkg::SHIFT_MAKE;
        end else if ((i_modifier_bits == hidsc1_pkg::MOD_CTRL) &&
                     (r_prior_mod != hidsc1_pkg::MOD_CTRL)) begin
            o_job.pend[hidsc1_pkg::POS_MOD_MAKE] = 1'b1;
            o_job.seq[hidsc1_pkg::POS_MOD_MAKE]  = hidsc1_pkg::CTRL_MAKE;
        end

        if (prior_shift) begin
            if (!new_shift) begin
                o_job.pend[hidsc1_pkg::POS_MOD_BREAK] = 1'b1;
                o_job.seq[hidsc1_pkg::POS_MOD_BREAK]  = hidsc1_pkg::SHIFT_BREAK;
            end
        end else if ((r_prior_mod == hidsc1_pkg::MOD_CTRL) &&
                     (i_modifier_bits != hidsc1_pkg::MOD_CTRL)) begin
            o_job.pend[hidsc1_pkg::POS_MOD_BREAK] = 1'b1;
            o_job.seq[hidsc1_pkg::POS_MOD_BREAK]  = hidsc1_pkg::CTRL_BREAK;
            o_job.pend[hidsc1_pkg::POS_CTRL_TAIL] = 1'b1;
            o_job.seq[hidsc1_pkg::POS_CTRL_TAIL]  = hidsc1_pkg::SHIFT_BREAK;
        end

        for (int i = 0; i < S; i++) begin
            o_job.pend[hidsc1_pkg::POS_KEY_MAKE + i] =
                (i_keys[i] != 8'h00) && !held_new[i] && hidsc1_pkg::in_range(i_keys[i]);
            o_job.seq[hidsc1_pkg::POS_KEY_MAKE + i]  = hidsc1_pkg::usage_map(i_keys[i]);
            o_job.pend[hidsc1_pkg::POS_KEY_BREAK + i] =
                (r_prior_keys[i] != 8'h00) && !held_old[i] &&
                hidsc1_pkg::in_range(r_prior_keys[i]);
            o_job.seq[hidsc1_pkg::POS_KEY_BREAK + i]  =
                hidsc1_pkg::usage_map(r_prior_keys[i]) | hidsc1_pkg::BREAK_BIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_mod <= '0;
            for (int i = 0; i < S; i++) begin
                r_prior_keys[i] <= '0;
            end
        end else if (accept) begin
            r_prior_mod <= i_modifier_bits;
            for (int i = 0; i < S; i++) begin
                r_prior_keys[i] <= i_keys[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/hidsc1_back.sv
// ----------------------------------------------------------------------------
// hidsc1_back
// Walk a scancode run one position a cycle into the free output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hidsc1_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire hidsc1_pkg::t_job  i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_scan_byte,
    output logic                   o_run_end
);

    localparam int NPOS = hidsc1_pkg::NPOS;

    hidsc1_pkg::t_job r_job, n_job;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_end, n_out_end;
    logic             out_free;
    logic             step;

    assign out_free    = !r_out_valid || i_ready;
    assign o_pop       = (r_job.pend == '0) && !i_empty;
    assign step        = (r_job.pend != '0) && (!r_job.pend[0] || out_free);
    assign o_valid     = r_out_valid;
    assign o_scan_byte = r_out_byte;
    assign o_run_end   = r_out_end;

    always_comb begin
        n_job       = r_job;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        if (o_pop) begin
            n_job = i_job;
        end else if (step) begin
            // advance one position; emit it when pending
            n_job.pend = {1'b0, r_job.pend[NPOS-1:1]};
            n_job.seq  = {8'h00, r_job.seq[NPOS-1:1]};
            if (r_job.pend[0]) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_job.seq[0];
                n_out_end   = (r_job.pend[NPOS-1:1] == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.pend  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_job.pend  <= n_job.pend;
            r_out_valid <= n_out_valid;
        end
        r_job.seq  <= n_job.seq;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

endmodule

`default_nettype wire

### rtl/hid_report_to_scancode_set1_top.sv
// ----------------------------------------------------------------------------
// hid_report_to_scancode_set1_top
// Boot-keyboard report to PS/2 set-1 scancode translator.
//
// channel  direction  handshake            payload
// report   in         i_valid / o_ready    i_modifier_bits, i_key_a .. i_key_f
// scancode out        o_valid / i_ready    o_scan_byte, o_run_end
//
// A report is classified in the cycle of its transfer and queued as a run.
// The sequencer loads a run once the previous one has left, then walks it
// position by position up to the last scancode, stalling on a held output.
// A report that changes nothing produces no scancode and is not queued.
// Reset clears the stored report, the queue and the output register.
// Either side may stall; the queue decouples classifier and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hid_report_to_scancode_set1_top_defines.svh"

module hid_report_to_scancode_set1_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_modifier_bits,
    input  wire logic [7:0]  i_key_a,
    input  wire logic [7:0]  i_key_b,
    input  wire logic [7:0]  i_key_c,
    input  wire logic [7:0]  i_key_d,
    input  wire logic [7:0]  i_key_e,
    input  wire logic [7:0]  i_key_f,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_scan_byte,
    output logic             o_run_end
);

    logic [7:0]        keys [hidsc1_pkg::KEY_SLOTS];
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    hidsc1_pkg::t_job  w_push_job;
    hidsc1_pkg::t_job  w_pop_job;

    assign keys[0] = i_key_a;
    assign keys[1] = i_key_b;
    assign keys[2] = i_key_c;
    assign keys[3] = i_key_d;
    assign keys[4] = i_key_e;
    assign keys[5] = i_key_f;

    hidsc1_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_modifier_bits (i_modifier_bits),
        .i_keys          (keys),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    hidsc1_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    hidsc1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_scan_byte (o_scan_byte),
        .o_run_end   (o_run_end)
    );

    `HIDSC1_ASSERT_NEVER(a_pop_empty, w_pop && w_empty, "pop from empty queue")
    `HIDSC1_ASSERT_NEVER(a_push_full, w_push && w_full, "push into full queue")
    `HIDSC1_ASSERT_IMPLY(a_push_xfer, w_push, i_valid && o_ready, "push without transfer")
    `HIDSC1_ASSERT_NEXT(a_rst_quiet, !i_rst_n, !o_valid, "output valid after reset")

endmodule

`default_nettype wire

### bench/tb_hid_report_to_scancode_set1_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the boot-keyboard report to set-1 scancode translator
// Drives reports through the valid/ready input channel and checks every
// scancode against a behavioural predictor that keeps its own copy of the
// previous report. Directed modifier and key cases, randomised report
// sequences under several idling mixes, and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_hid_report_to_scancode_set1_top;

    localparam int KEY_COUNT        = 6;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 40;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int PRINT_CAP        = 30;

    localparam logic [7:0] MOD_NONE    = 8'd0;
    localparam logic [7:0] CTRL_ONLY   = 8'd1;
    localparam logic [7:0] SHIFT_LEFT  = 8'd2;
    localparam logic [7:0] SHIFT_RIGHT = 8'd32;
    localparam logic [7:0] SC_SHIFT    = 8'h2A;
    localparam logic [7:0] SC_CTRL     = 8'h1D;
    localparam logic [7:0] BREAK_FLAG  = 8'h80;
    localparam logic [7:0] USAGE_BOUND = 8'h47;

    localparam int SEND_IDLE  [4] = '{0, 87, 0, 20};
    localparam int RECV_STALL [4] = '{0, 0, 87, 20};

    localparam logic [7:0] SET1_CODE [0:70] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
        8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00
    };

    typedef logic [7:0] t_key_row [KEY_COUNT];

    typedef struct packed {
        logic [7:0] scan;
        logic       last;
    } t_scan_entry;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_modifier_bits;
    logic [7:0] i_key_a;
    logic [7:0] i_key_b;
    logic [7:0] i_key_c;
    logic [7:0] i_key_d;
    logic [7:0] i_key_e;
    logic [7:0] i_key_f;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_scan_byte;
    logic       o_run_end;

    logic [7:0]  held_mods = 8'd0;
    t_key_row    held_keys = '{default: 8'd0};
    t_scan_entry pending_scans [$];

    int  send_idle_pct   = 0;
    int  recv_stall_pct  = 0;
    logic holding        = 1'b0;
    int  mismatches      = 0;
    int  reports_sent    = 0;
    int  scans_checked   = 0;
    int  input_stalls    = 0;
    int  quiet_cycles    = 0;
    event start_hold;

    hid_report_to_scancode_set1_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_modifier_bits (i_modifier_bits),
        .i_key_a         (i_key_a),
        .i_key_b         (i_key_b),
        .i_key_c         (i_key_c),
        .i_key_d         (i_key_d),
        .i_key_e         (i_key_e),
        .i_key_f         (i_key_f),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scan_byte     (o_scan_byte),
        .o_run_end       (o_run_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic bit is_shift(input logic [7:0] mods);
        return mods == SHIFT_LEFT || mods == SHIFT_RIGHT;
    endfunction

    function automatic bit key_in(input t_key_row row, input logic [7:0] code);
        foreach (row[i]) begin
            if (row[i] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    // work out the scancode run of one report and advance the stored report
    function automatic void predict_scancodes(input logic [7:0] mods, input t_key_row keys);
        logic [7:0] codes [$];
        logic [7:0] k;
        if (is_shift(mods) && held_mods != mods) begin
            codes.push_back(SC_SHIFT);
        end else if (mods == CTRL_ONLY && held_mods != CTRL_ONLY) begin
            codes.push_back(SC_CTRL);
        end
        if (is_shift(held_mods)) begin
            if (!is_shift(mods)) codes.push_back(SC_SHIFT | BREAK_FLAG);
        end else if (held_mods == CTRL_ONLY) begin
            if (mods != CTRL_ONLY) begin
                codes.push_back(SC_CTRL | BREAK_FLAG);
                codes.push_back(SC_SHIFT | BREAK_FLAG);
            end
        end
        for (int i = 0; i < KEY_COUNT; i++) begin
            k = keys[i];
            if (k != 8'd0 && k < USAGE_BOUND && !key_in(held_keys, k)) begin
                codes.push_back(SET1_CODE[k]);
            end
        end
        for (int i = 0; i < KEY_COUNT; i++) begin
            k = held_keys[i];
            if (k != 8'd0 && k < USAGE_BOUND && !key_in(keys, k)) begin
                codes.push_back(SET1_CODE[k] | BREAK_FLAG);
            end
        end
        foreach (codes[i]) begin
            pending_scans.push_back('{scan: codes[i], last: (i == codes.size() - 1)});
        end
        held_mods = mods;
        held_keys = keys;
    endfunction

    task automatic send_report(input logic [7:0] mods, input t_key_row keys);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_modifier_bits <= mods;
        i_key_a         <= keys[0];
        i_key_b         <= keys[1];
        i_key_c         <= keys[2];
        i_key_d         <= keys[3];
        i_key_e         <= keys[4];
        i_key_f         <= keys[5];
        @(posedge i_clk);
        while (!o_ready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        predict_scancodes(mods, keys);
        reports_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge i_clk);
    endtask

    // mostly small edits to the held report, some raw noise, some repeats
    function automatic void make_report(output logic [7:0] mods, output t_key_row keys);
        int pick;
        int slot;
        mods = held_mods;
        keys = held_keys;
        pick = $urandom_range(99);
        if (pick < 70) begin
            repeat ($urandom_range(1, 3)) begin
                slot = $urandom_range(KEY_COUNT - 1);
                case ($urandom_range(5))
                    0: keys[slot] = 8'd0;
                    1: keys[slot] = keys[$urandom_range(KEY_COUNT - 1)];
                    2: keys[slot] = 8'($urandom_range(255));
                    default: keys[slot] = 8'($urandom_range(1, 8'h46));
                endcase
            end
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(4))
                    0: mods = MOD_NONE;
                    1: mods = CTRL_ONLY;
                    2: mods = SHIFT_LEFT;
                    3: mods = SHIFT_RIGHT;
                    default: mods = 8'($urandom_range(255));
                endcase
            end
        end else if (pick < 88) begin
            mods = 8'($urandom_range(255));
            foreach (keys[i]) keys[i] = 8'($urandom_range(255));
        end
    endfunction

    task automatic test_modifier_transitions();
        logic [7:0] seq [13];
        t_key_row   empty_row;
        empty_row = '{default: 8'd0};
        seq = '{SHIFT_LEFT, SHIFT_RIGHT, MOD_NONE, CTRL_ONLY, SHIFT_LEFT, CTRL_ONLY,
                MOD_NONE, 8'hFF, SHIFT_RIGHT, 8'd3, CTRL_ONLY, CTRL_ONLY, MOD_NONE};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (seq[i]) send_report(seq[i], empty_row);
        wait_drained();
    endtask

    task automatic test_key_extremes();
        t_key_row row;
        row = '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
        send_report(MOD_NONE, row);
        row = '{8'h39, 8'h46, 8'h01, 8'h47, 8'hFF, 8'h80};
        send_report(MOD_NONE, row);
        row = '{8'h39, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00};
        send_report(MOD_NONE, row);
        row = '{8'h2C, 8'h2C, 8'h7F, 8'h00, 8'h03, 8'hFE};
        send_report(MOD_NONE, row);
        row = '{8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F};
        send_report(CTRL_ONLY, row);
        // every modifier and key slot changes at once: the longest run
        row = '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23};
        send_report(SHIFT_LEFT, row);
        send_report(SHIFT_LEFT, row);
        row = '{default: 8'd0};
        send_report(MOD_NONE, row);
        send_report(MOD_NONE, row);
        wait_drained();
    endtask

    task automatic test_random_reports();
        logic [7:0] mods;
        t_key_row   keys;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            repeat (RANDOM_PER_PHASE) begin
                make_report(mods, keys);
                send_report(mods, keys);
            end
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        logic [7:0] mods;
        t_key_row   keys;
        -> start_hold;
        repeat (20) begin
            mods = (held_mods == SHIFT_LEFT) ? CTRL_ONLY : SHIFT_LEFT;
            foreach (keys[i]) keys[i] = 8'($urandom_range(4, 8'h46));
            send_report(mods, keys);
        end
        wait_drained();
    endtask

    // hold the scancode channel off for a long stretch
    always begin
        @(start_hold);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_scan_entry want;
        if (i_rst_n && o_valid && i_ready) begin
            scans_checked++;
            if (pending_scans.size() == 0) begin
                report_mismatch($sformatf("unexpected scancode %02h", o_scan_byte));
            end else begin
                want = pending_scans.pop_front();
                if (o_scan_byte !== want.scan) begin
                    report_mismatch($sformatf("scan_byte %02h, want %02h",
                                              o_scan_byte, want.scan));
                end
                if (o_run_end !== want.last) begin
                    report_mismatch($sformatf("run_end %0b, want %0b on scancode %02h",
                                              o_run_end, want.last, want.scan));
                end
            end
        end
        i_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_hid_report_to_scancode_set1_top: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_modifier_bits = 8'd0;
        i_key_a         = 8'd0;
        i_key_b         = 8'd0;
        i_key_c         = 8'd0;
        i_key_d         = 8'd0;
        i_key_e         = 8'd0;
        i_key_f         = 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_modifier_transitions();
        test_key_extremes();
        test_random_reports();
        test_output_backpressure();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_scans.size() != 0) begin
            report_mismatch($sformatf("%0d scancodes never arrived", pending_scans.size()));
        end
        $display("covered %0d reports: modifier transitions, key extremes, random edits",
                 reports_sent);
        $display("checked %0d scancodes; input held off for %0d cycles under back-pressure",
                 scans_checked, input_stalls);
        if (mismatches == 0) begin
            $display("tb_hid_report_to_scancode_set1_top: PASS");
        end else begin
            $display("tb_hid_report_to_scancode_set1_top: FAIL");
        end
        $finish;
    end

endmodule
